[hdl/gfc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfc_pkg
// Shared types and constants for the gamepad frame conditioner.
// ----------------------------------------------------------------------------
package gfc_pkg;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_SOCD_EN    = 3'd0,
		REG_DZ_EN      = 3'd1,
		REG_LEFT_DZ    = 3'd2,
		REG_RIGHT_DZ   = 3'd3,
		REG_LEFT_ANTI  = 3'd4,
		REG_RIGHT_ANTI = 3'd5
	} cfg_reg_t;

	localparam logic [15:0] Q_ONE         = 16'h8000;
	// 32767 squared: full-scale normalizer for the squared magnitude
	localparam logic [31:0] AXIS_FULL_SQ  = 32'd1073676289;
	localparam logic [15:0] DZ_RESET      = 16'd4915;

	localparam logic [15:0] DPAD_UD       = 16'h0003;
	localparam logic [15:0] DPAD_LR       = 16'h000C;

	// Stage counts of the stick lane
	localparam int CD_STAGES  = 3;   // normalize by 32767 squared: two folds, one compare
	localparam int SQ_STAGES  = 16;  // square root, one root bit per stage
	localparam int ND_STAGES  = 15;  // rescale divide
	localparam int OD_STAGES  = 15;  // axis divide after the range check
	localparam int LANE_LAT   = 1 + CD_STAGES + SQ_STAGES + 1 + ND_STAGES + 1 + 1 + 1
		+ 1 + OD_STAGES + 1;

	typedef struct packed {
		logic        dz_on;
		logic [15:0] dz;
		logic [15:0] anti;
	} lane_cfg_t;

endpackage
`default_nettype wire

[hdl/gamepad_frame_conditioner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_frame_conditioner
// Opposing-direction cleaning and scaled radial deadzone for gamepad frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one frame per beat: a button word
//   and two signed stick pairs. Output channel (out_valid/out_stall) returns
//   one cleaned frame per accepted beat, in order.
//   From input beat to output beat a frame passes through the square and sum,
//   three normalize stages, one stage per root bit and per quotient bit of
//   the two variable divides, and the deadzone test, lift, product and range
//   check stages and the output register.
//   Throughput, while no beat is stalled, is one frame per cycle: two stick
//   lanes and a button lane run side by side, their outputs forming one beat.
//   When the receiver stalls a waiting beat, the whole pipeline holds and
//   in_stall is raised in the same cycle; it drops as soon as the beat is
//   taken.
//   Reset clears the valid pipeline and loads the register defaults: SOCD on,
//   deadzone on, deadzones 4915, anti-deadzones 0.
//   Write configuration only while no frame is in flight.
// ----------------------------------------------------------------------------
module gamepad_frame_conditioner (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic        [15:0] buttons,
	input  wire logic signed [15:0] left_x,
	input  wire logic signed [15:0] left_y,
	input  wire logic signed [15:0] right_x,
	input  wire logic signed [15:0] right_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic             [15:0] clean_buttons,
	output logic signed      [15:0] out_left_x,
	output logic signed      [15:0] out_left_y,
	output logic signed      [15:0] out_right_x,
	output logic signed      [15:0] out_right_y,
	input  wire logic               cfg_we,
	input  wire logic        [2:0]  cfg_index,
	input  wire logic        [15:0] cfg_data
);
	localparam int LAT = gfc_pkg::LANE_LAT;

	// Configuration registers
	logic        socd_q, dz_en_q;
	logic [15:0] left_dz_q, right_dz_q, left_anti_q, right_anti_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			socd_q       <= 1'b1;
			dz_en_q      <= 1'b1;
			left_dz_q    <= gfc_pkg::DZ_RESET;
			right_dz_q   <= gfc_pkg::DZ_RESET;
			left_anti_q  <= '0;
			right_anti_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gfc_pkg::REG_SOCD_EN:    socd_q       <= cfg_data[0];
				gfc_pkg::REG_DZ_EN:      dz_en_q      <= cfg_data[0];
				gfc_pkg::REG_LEFT_DZ:    left_dz_q    <= cfg_data;
				gfc_pkg::REG_RIGHT_DZ:   right_dz_q   <= cfg_data;
				gfc_pkg::REG_LEFT_ANTI:  left_anti_q  <= cfg_data;
				gfc_pkg::REG_RIGHT_ANTI: right_anti_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance everything unless the output beat is waiting on the receiver
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Valid bits, one per stage
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end
	assign out_valid = vld_q[LAT-1];

	gfc_pkg::lane_cfg_t left_cfg, right_cfg;
	assign left_cfg  = '{dz_on: dz_en_q, dz: left_dz_q, anti: left_anti_q};
	assign right_cfg = '{dz_on: dz_en_q, dz: right_dz_q, anti: right_anti_q};

	gfc_button_lane u_buttons (
		.clk           (clk),
		.en            (en),
		.socd_on       (socd_q),
		.buttons       (buttons),
		.clean_buttons (clean_buttons)
	);

	gfc_stick_lane u_left (
		.clk (clk),
		.en  (en),
		.cfg (left_cfg),
		.x   (left_x),
		.y   (left_y),
		.ox  (out_left_x),
		.oy  (out_left_y)
	);

	gfc_stick_lane u_right (
		.clk (clk),
		.en  (en),
		.cfg (right_cfg),
		.x   (right_x),
		.y   (right_y),
		.ox  (out_right_x),
		.oy  (out_right_y)
	);
endmodule
`default_nettype wire

[hdl/gfc_button_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfc_button_lane
// Opposing-direction cancellation and delay matched to the stick lanes.
// ----------------------------------------------------------------------------
module gfc_button_lane (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic        socd_on,
	input  wire logic [15:0] buttons,
	output logic      [15:0] clean_buttons
);
	logic [15:0] socd_c;
	logic [15:0] bt_q [gfc_pkg::LANE_LAT];

	always_comb begin
		socd_c = buttons;
		if (socd_on) begin
			if ((buttons & gfc_pkg::DPAD_LR) == gfc_pkg::DPAD_LR)
				socd_c = socd_c & ~gfc_pkg::DPAD_LR;
			if ((buttons & gfc_pkg::DPAD_UD) == gfc_pkg::DPAD_UD)
				socd_c = socd_c & ~gfc_pkg::DPAD_UD;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bt_q[0] <= socd_c;
			for (int i = 1; i < gfc_pkg::LANE_LAT; i++)
				bt_q[i] <= bt_q[i-1];
		end
	end

	assign clean_buttons = bt_q[gfc_pkg::LANE_LAT-1];
endmodule
`default_nettype wire

[hdl/gfc_stick_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfc_stick_lane
// Pipelined scaled radial deadzone for one stick.
// ----------------------------------------------------------------------------
module gfc_stick_lane (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire gfc_pkg::lane_cfg_t       cfg,
	input  wire logic signed [15:0]       x,
	input  wire logic signed [15:0]       y,
	output logic signed      [15:0]       ox,
	output logic signed      [15:0]       oy
);
	localparam int SQN = gfc_pkg::SQ_STAGES;
	localparam int NDN = gfc_pkg::ND_STAGES;
	localparam int ODN = gfc_pkg::OD_STAGES;

	logic [15:0] dz_c, anti_c;
	assign dz_c   = (cfg.dz > gfc_pkg::Q_ONE) ? gfc_pkg::Q_ONE : cfg.dz;
	assign anti_c = (cfg.anti > gfc_pkg::Q_ONE) ? gfc_pkg::Q_ONE : cfg.anti;

	// Square and sum
	logic signed [31:0] xx_c, yy_c;
	logic signed [15:0] x_s1, y_s1;
	logic        [31:0] sq_s1;
	assign xx_c = x * x;
	assign yy_c = y * y;
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x;
			y_s1  <= y;
			sq_s1 <= $unsigned(xx_c) + $unsigned(yy_c);
		end
	end

	// Normalize: floor(S * 2^30 / D) with D = 2^30 - M, M = 2^16 - 1.
	// S * 2^30 = S * D + S * M, so the quotient is S plus floor(S * M / D).
	// Fold the part above 2^30 back in twice; what is left is below 2 * D
	// and needs one compare.
	logic        [46:0] nm_t_c;
	logic        [46:0] nm_t_s2;
	logic        [31:0] nm_acc_s2;
	logic signed [15:0] nm_x_s2, nm_y_s2;
	assign nm_t_c = 47'({sq_s1, 16'd0} - {16'd0, sq_s1});
	always_ff @(posedge clk) begin
		if (en) begin
			nm_t_s2   <= nm_t_c;
			nm_acc_s2 <= sq_s1;
			nm_x_s2   <= x_s1;
			nm_y_s2   <= y_s1;
		end
	end

	logic        [16:0] nm_a_c;
	logic        [33:0] nm_u_c;
	logic        [33:0] nm_u_s3;
	logic        [31:0] nm_acc_s3;
	logic signed [15:0] nm_x_s3, nm_y_s3;
	assign nm_a_c = nm_t_s2[46:30];
	assign nm_u_c = 34'({nm_a_c, 16'd0}) - 34'(nm_a_c) + 34'(nm_t_s2[29:0]);
	always_ff @(posedge clk) begin
		if (en) begin
			nm_u_s3   <= nm_u_c;
			nm_acc_s3 <= nm_acc_s2 + 32'(nm_a_c);
			nm_x_s3   <= nm_x_s2;
			nm_y_s3   <= nm_y_s2;
		end
	end

	logic        [3:0]  nm_c_c;
	logic        [30:0] nm_v_c;
	logic               nm_ge_c;
	logic        [31:0] nm_q_s4;
	logic signed [15:0] nm_x_s4, nm_y_s4;
	assign nm_c_c  = nm_u_s3[33:30];
	assign nm_v_c  = 31'({nm_c_c, 16'd0}) - 31'(nm_c_c) + 31'(nm_u_s3[29:0]);
	assign nm_ge_c = {1'b0, nm_v_c} >= gfc_pkg::AXIS_FULL_SQ;
	always_ff @(posedge clk) begin
		if (en) begin
			nm_q_s4 <= nm_acc_s3 + 32'(nm_c_c) + 32'(nm_ge_c);
			nm_x_s4 <= nm_x_s3;
			nm_y_s4 <= nm_y_s3;
		end
	end

	// Integer square root, one root bit per stage
	logic        [17:0] sq_rem  [SQN+1];
	logic        [15:0] sq_root [SQN+1];
	logic        [31:0] sq_v    [SQN+1];
	logic signed [15:0] sq_x    [SQN+1];
	logic signed [15:0] sq_y    [SQN+1];
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_v[0]    = nm_q_s4;
	assign sq_x[0]    = nm_x_s4;
	assign sq_y[0]    = nm_y_s4;

	for (genvar j = 0; j < SQN; j++) begin : g_sq
		logic [19:0] t;
		logic [19:0] trial;
		logic        ge;
		assign t     = {sq_rem[j], sq_v[j][31:30]};
		assign trial = {2'b00, sq_root[j], 2'b01};
		assign ge    = t >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem[j+1]  <= ge ? 18'(t - trial) : t[17:0];
				sq_root[j+1] <= {sq_root[j][14:0], ge};
				sq_v[j+1]    <= {sq_v[j][29:0], 2'b00};
				sq_x[j+1]    <= sq_x[j];
				sq_y[j+1]    <= sq_y[j];
			end
		end
	end

	// Deadzone test
	logic [15:0] mag_c;
	logic [15:0] nd_d_s;
	assign mag_c = sq_root[SQN];

	logic        [15:0] nd_r    [NDN+1];
	logic        [14:0] nd_q    [NDN+1];
	logic        [15:0] nd_mag  [NDN+1];
	logic               nd_zero [NDN+1];
	logic               nd_sat  [NDN+1];
	logic signed [15:0] nd_x    [NDN+1];
	logic signed [15:0] nd_y    [NDN+1];

	always_ff @(posedge clk) begin
		if (en) begin
			nd_d_s     <= 16'(17'h10000 - 17'(dz_c) - 17'h08000);
			nd_r[0]    <= mag_c - dz_c;
			nd_q[0]    <= '0;
			nd_mag[0]  <= mag_c;
			nd_zero[0] <= (mag_c < dz_c) || (mag_c == '0);
			nd_sat[0]  <= mag_c[15];
			nd_x[0]    <= sq_x[SQN];
			nd_y[0]    <= sq_y[SQN];
		end
	end

	// Rescale divide: (mag - dz) * 2^15 / (2^15 - dz)
	for (genvar k = 0; k < NDN; k++) begin : g_nd
		logic [16:0] t;
		logic        ge;
		assign t  = {nd_r[k], 1'b0};
		assign ge = t >= {1'b0, nd_d_s};
		always_ff @(posedge clk) begin
			if (en) begin
				nd_r[k+1]    <= ge ? 16'(t - {1'b0, nd_d_s}) : t[15:0];
				nd_q[k+1]    <= {nd_q[k][13:0], ge};
				nd_mag[k+1]  <= nd_mag[k];
				nd_zero[k+1] <= nd_zero[k];
				nd_sat[k+1]  <= nd_sat[k];
				nd_x[k+1]    <= nd_x[k];
				nd_y[k+1]    <= nd_y[k];
			end
		end
	end

	// Anti-deadzone lift
	logic [15:0] n_c;
	logic [15:0] anti_m_c;
	assign n_c      = nd_sat[NDN] ? gfc_pkg::Q_ONE : {1'b0, nd_q[NDN]};
	assign anti_m_c = 16'(17'h08000 - 17'(anti_c));

	logic        [31:0] prod_s1;
	logic        [15:0] n_s1, mag_s1, mag_s2;
	logic               zero_s1, zero_s2;
	logic signed [15:0] ax_s1, ay_s1, ax_s2, ay_s2;
	logic        [15:0] n2_s2;
	logic        [17:0] lift_c;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 32'(anti_m_c) * 32'(n_c);
			n_s1    <= n_c;
			mag_s1  <= nd_mag[NDN];
			zero_s1 <= nd_zero[NDN];
			ax_s1   <= nd_x[NDN];
			ay_s1   <= nd_y[NDN];
		end
	end

	assign lift_c = 18'(anti_c) + 18'(prod_s1[31:15]);

	always_ff @(posedge clk) begin
		if (en) begin
			if (anti_c != '0 && n_s1 != '0)
				n2_s2 <= (lift_c > 18'(gfc_pkg::Q_ONE)) ? gfc_pkg::Q_ONE : lift_c[15:0];
			else
				n2_s2 <= n_s1;
			mag_s2  <= mag_s1;
			zero_s2 <= zero_s1;
			ax_s2   <= ax_s1;
			ay_s2   <= ay_s1;
		end
	end

	// Axis magnitude times scaled length
	logic [15:0] absx_c, absy_c;
	assign absx_c = ax_s2[15] ? 16'(~ax_s2 + 16'sd1) : ax_s2;
	assign absy_c = ay_s2[15] ? 16'(~ay_s2 + 16'sd1) : ay_s2;

	logic        [30:0] px_s3, py_s3;
	logic        [15:0] mag_s3;
	logic               zero_s3;
	logic signed [15:0] ax_s3, ay_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			px_s3   <= 31'(32'(absx_c) * 32'(n2_s2));
			py_s3   <= 31'(32'(absy_c) * 32'(n2_s2));
			mag_s3  <= mag_s2;
			zero_s3 <= zero_s2;
			ax_s3   <= ax_s2;
			ay_s3   <= ay_s2;
		end
	end

	// Axis divide: range check, then one quotient bit per stage
	logic        [15:0] odx_r  [ODN+1];
	logic        [15:0] ody_r  [ODN+1];
	logic        [14:0] odx_q  [ODN+1];
	logic        [14:0] ody_q  [ODN+1];
	logic        [14:0] odx_lo [ODN+1];
	logic        [14:0] ody_lo [ODN+1];
	logic               odx_big[ODN+1];
	logic               ody_big[ODN+1];
	logic        [15:0] od_mag [ODN+1];
	logic               od_zero[ODN+1];
	logic signed [15:0] od_x   [ODN+1];
	logic signed [15:0] od_y   [ODN+1];

	always_ff @(posedge clk) begin
		if (en) begin
			odx_big[0] <= px_s3 >= {mag_s3, 15'd0};
			ody_big[0] <= py_s3 >= {mag_s3, 15'd0};
			odx_r[0]   <= px_s3[30:15];
			ody_r[0]   <= py_s3[30:15];
			odx_lo[0]  <= px_s3[14:0];
			ody_lo[0]  <= py_s3[14:0];
			odx_q[0]   <= '0;
			ody_q[0]   <= '0;
			od_mag[0]  <= mag_s3;
			od_zero[0] <= zero_s3;
			od_x[0]    <= ax_s3;
			od_y[0]    <= ay_s3;
		end
	end

	for (genvar k = 0; k < ODN; k++) begin : g_od
		logic [16:0] tx, ty;
		logic        gx, gy;
		assign tx = {odx_r[k], odx_lo[k][14]};
		assign ty = {ody_r[k], ody_lo[k][14]};
		assign gx = tx >= {1'b0, od_mag[k]};
		assign gy = ty >= {1'b0, od_mag[k]};
		always_ff @(posedge clk) begin
			if (en) begin
				odx_r[k+1]   <= gx ? 16'(tx - {1'b0, od_mag[k]}) : tx[15:0];
				ody_r[k+1]   <= gy ? 16'(ty - {1'b0, od_mag[k]}) : ty[15:0];
				odx_q[k+1]   <= {odx_q[k][13:0], gx};
				ody_q[k+1]   <= {ody_q[k][13:0], gy};
				odx_lo[k+1]  <= {odx_lo[k][13:0], 1'b0};
				ody_lo[k+1]  <= {ody_lo[k][13:0], 1'b0};
				odx_big[k+1] <= odx_big[k];
				ody_big[k+1] <= ody_big[k];
				od_mag[k+1]  <= od_mag[k];
				od_zero[k+1] <= od_zero[k];
				od_x[k+1]    <= od_x[k];
				od_y[k+1]    <= od_y[k];
			end
		end
	end

	// Sign, saturate, bypass
	function automatic logic [15:0] finish(input logic neg, input logic big,
		input logic [14:0] q);
		logic [15:0] r;
		if (big)
			r = neg ? 16'h8000 : 16'h7FFF;
		else if (neg)
			r = 16'(~{1'b0, q} + 16'd1);
		else
			r = {1'b0, q};
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			if (!cfg.dz_on) begin
				ox <= od_x[ODN];
				oy <= od_y[ODN];
			end else if (od_zero[ODN]) begin
				ox <= '0;
				oy <= '0;
			end else begin
				ox <= finish(od_x[ODN][15], odx_big[ODN], odx_q[ODN]);
				oy <= finish(od_y[ODN][15], ody_big[ODN], ody_q[ODN]);
			end
		end
	end
endmodule
`default_nettype wire

[hdl/gfc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfc_checker
// Port-level checks for the gamepad frame conditioner.
// ----------------------------------------------------------------------------
module gfc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [15:0] clean_buttons,
	input wire logic [15:0] out_left_x
);
	// Stall input only when a finished beat is held
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output beat");

	// Never stall input while the output is free
	a_free_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled while output free");

	// A stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(clean_buttons) && $stable(out_left_x)))
		else $error("stalled output beat changed");
endmodule

bind gamepad_frame_conditioner gfc_checker u_gfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.clean_buttons (clean_buttons),
	.out_left_x    (out_left_x)
);
`default_nettype wire

[verif/gamepad_frame_conditioner_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_frame_conditioner_tb
// Self-checking bench: queued frames are pushed through the conditioner under
// several idle and stall mixes and register settings; every output beat is
// compared field by field with a frame predicted by the bench itself.
// ----------------------------------------------------------------------------
module gamepad_frame_conditioner_tb;

	localparam int LAT          = gfc_pkg::LANE_LAT;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic        [15:0] btn;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
	} frame_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic        [15:0] buttons;
	logic signed [15:0] left_x, left_y, right_x, right_y;
	logic               out_valid;
	logic               out_stall;
	logic        [15:0] clean_buttons;
	logic signed [15:0] out_left_x, out_left_y, out_right_x, out_right_y;
	logic               cfg_we;
	logic        [2:0]  cfg_index;
	logic        [15:0] cfg_data;

	// Bench copy of the register file
	logic        socd_on, dz_on;
	logic [15:0] dz_l, dz_r, anti_l, anti_r;

	frame_t pending_frames[$];
	frame_t expected_frames[$];
	int     error_count;
	int     cycle_count;
	int     send_idle_pct, recv_stall_pct;
	int     hold_off_cycles;

	gamepad_frame_conditioner i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.buttons(buttons), .left_x(left_x), .left_y(left_y),
		.right_x(right_x), .right_y(right_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.clean_buttons(clean_buttons),
		.out_left_x(out_left_x), .out_left_y(out_left_y),
		.out_right_x(out_right_x), .out_right_y(out_right_y),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Integer square root, rounded down
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [15:0] sat_axis(longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// Scaled radial deadzone for one stick
	function automatic void deadzone_stick(input logic signed [15:0] x,
		input logic signed [15:0] y, input logic [15:0] dz_raw,
		input logic [15:0] anti_raw, output logic [15:0] ox, output logic [15:0] oy);
		longint unsigned dz, anti, s, mag, n;
		longint xi, yi;
		dz   = (dz_raw > gfc_pkg::Q_ONE) ? gfc_pkg::Q_ONE : dz_raw;
		anti = (anti_raw > gfc_pkg::Q_ONE) ? gfc_pkg::Q_ONE : anti_raw;
		xi   = x;
		yi   = y;
		s    = xi * xi + yi * yi;
		mag  = int_sqrt((s << 30) / gfc_pkg::AXIS_FULL_SQ);
		if (mag < dz || mag == 0) begin
			ox = '0;
			oy = '0;
			return;
		end
		if (dz == gfc_pkg::Q_ONE)
			n = gfc_pkg::Q_ONE;
		else
			n = ((mag - dz) * gfc_pkg::Q_ONE) / (gfc_pkg::Q_ONE - dz);
		if (anti > 0 && n > 0)
			n = anti + (((gfc_pkg::Q_ONE - anti) * n) >> 15);
		if (n > gfc_pkg::Q_ONE)
			n = gfc_pkg::Q_ONE;
		ox = sat_axis((xi * longint'(n)) / longint'(mag));
		oy = sat_axis((yi * longint'(n)) / longint'(mag));
	endfunction

	function automatic frame_t condition_frame(frame_t f);
		frame_t r;
		r.btn = f.btn;
		if (socd_on) begin
			if ((r.btn & gfc_pkg::DPAD_LR) == gfc_pkg::DPAD_LR)
				r.btn &= ~gfc_pkg::DPAD_LR;
			if ((r.btn & gfc_pkg::DPAD_UD) == gfc_pkg::DPAD_UD)
				r.btn &= ~gfc_pkg::DPAD_UD;
		end
		if (dz_on) begin
			deadzone_stick(f.lx, f.ly, dz_l, anti_l, r.lx, r.ly);
			deadzone_stick(f.rx, f.ry, dz_r, anti_r, r.rx, r.ry);
		end else begin
			r.lx = f.lx; r.ly = f.ly; r.rx = f.rx; r.ry = f.ry;
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("mismatch on %s: got %0d, expected %0d", field, got, want);
		error_count++;
	endtask

	// Driver: offer the head of the queue; advance on an accepted beat
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			frame_t f;
			bit busy;
			busy = in_valid && in_stall;
			if (in_valid && !in_stall)
				expected_frames.insert(expected_frames.size(),
					condition_frame(pending_frames.pop_front()));
			if (!busy) begin
				if (pending_frames.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					f = pending_frames[0];
					in_valid <= 1'b1;
					buttons  <= f.btn;
					left_x   <= f.lx;
					left_y   <= f.ly;
					right_x  <= f.rx;
					right_y  <= f.ry;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall, with a long hold-off counted down on request
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			out_stall <= 1'b1;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: check each beat against the oldest expected frame
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_frames.size() == 0) begin
				report_mismatch("unexpected beat", clean_buttons, 0);
			end else begin
				frame_t e;
				e = expected_frames.pop_front();
				if (clean_buttons !== e.btn)
					report_mismatch("clean_buttons", clean_buttons, e.btn);
				if (out_left_x !== e.lx)
					report_mismatch("out_left_x", out_left_x, e.lx);
				if (out_left_y !== e.ly)
					report_mismatch("out_left_y", out_left_y, e.ly);
				if (out_right_x !== e.rx)
					report_mismatch("out_right_x", out_right_x, e.rx);
				if (out_right_y !== e.ry)
					report_mismatch("out_right_y", out_right_y, e.ry);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'($urandom_range(600) - 300);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_random(int count);
		frame_t f;
		repeat (count) begin
			f.btn = 16'($urandom);
			f.lx  = rand_axis();
			f.ly  = rand_axis();
			f.rx  = rand_axis();
			f.ry  = rand_axis();
			pending_frames.insert(pending_frames.size(), f);
		end
	endtask

	task automatic queue_frame(logic [15:0] b, logic signed [15:0] lx,
		logic signed [15:0] ly, logic signed [15:0] rx, logic signed [15:0] ry);
		frame_t f;
		f = '{b, lx, ly, rx, ry};
		pending_frames.insert(pending_frames.size(), f);
	endtask

	// Drain everything, then let the pipeline settle before touching registers
	task automatic wait_drained();
		while (pending_frames.size() > 0 || in_valid || expected_frames.size() > 0)
			@(posedge clk);
		repeat (LAT + 10) @(posedge clk);
	endtask

	// Leaves the write enable high; set_regs drops it after the last write
	task automatic write_reg(gfc_pkg::cfg_reg_t idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			gfc_pkg::REG_SOCD_EN:    socd_on = val[0];
			gfc_pkg::REG_DZ_EN:      dz_on   = val[0];
			gfc_pkg::REG_LEFT_DZ:    dz_l    = val;
			gfc_pkg::REG_RIGHT_DZ:   dz_r    = val;
			gfc_pkg::REG_LEFT_ANTI:  anti_l  = val;
			gfc_pkg::REG_RIGHT_ANTI: anti_r  = val;
			default: ;
		endcase
	endtask

	task automatic set_regs(logic s, logic d, logic [15:0] a, logic [15:0] b,
		logic [15:0] c, logic [15:0] e);
		write_reg(gfc_pkg::REG_SOCD_EN, 16'(s));
		write_reg(gfc_pkg::REG_DZ_EN, 16'(d));
		write_reg(gfc_pkg::REG_LEFT_DZ, a);
		write_reg(gfc_pkg::REG_RIGHT_DZ, b);
		write_reg(gfc_pkg::REG_LEFT_ANTI, c);
		write_reg(gfc_pkg::REG_RIGHT_ANTI, e);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; out_stall = 1'b0; cfg_we = 1'b0;
		cfg_index = '0; cfg_data = '0;
		buttons = '0; left_x = '0; left_y = '0; right_x = '0; right_y = '0;
		error_count = 0; cycle_count = 0; hold_off_cycles = 0;
		send_idle_pct = 0; recv_stall_pct = 0;
		socd_on = 1; dz_on = 1; dz_l = gfc_pkg::DZ_RESET; dz_r = gfc_pkg::DZ_RESET;
		anti_l = '0; anti_r = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at reset settings: dpad pairs, axis extremes, zero stick
		queue_frame(16'h0000, 0, 0, 0, 0);
		queue_frame(16'h000F, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
		queue_frame(16'h000C, 16'sh8000, 0, 0, 16'sh7FFF);
		queue_frame(16'h0003, 100, -100, 4000, 3000);
		queue_frame(16'hFFF5, 16'sh8000, 16'sh7FFF, 5000, 0);
		queue_frame(16'hFFFF, 4915, 0, -4915, 0);
		wait_drained();

		// Deadzone of one and full anti-deadzone; registers above 32768
		set_regs(1'b0, 1'b1, 16'h8000, 16'hFFFF, 16'h8000, 16'h0000);
		queue_frame(16'h000F, 16'sh7FFF, 0, 16'sh8000, 16'sh8000);
		queue_frame(16'h000C, 16'sh8000, 16'sh8000, 16'sh7FFF, 0);
		queue_frame(16'h0003, 100, 100, 0, 0);
		wait_drained();

		// Zero deadzone with zero stick, and anti-deadzone lift
		set_regs(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h4000, 16'hFFFF);
		queue_frame(16'h0005, 0, 0, 0, 0);
		queue_frame(16'h000A, 1, 0, 0, -1);
		queue_frame(16'h0000, 16'sh8000, 16'sh8000, 20000, -20000);
		wait_drained();

		// Deadzone bypass
		set_regs(1'b0, 1'b0, 16'd4915, 16'd4915, 16'd0, 16'd0);
		queue_frame(16'h000F, 16'sh8000, 16'sh7FFF, 123, -456);
		queue_frame(16'hFFFF, -1, 1, 16'sh7FFF, 16'sh8000);
		wait_drained();

		// Random phases: each idle mix under a fresh register setting
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				3: begin send_idle_pct = 15; recv_stall_pct = 15; end
				4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			if (ph == 0)
				set_regs(1'b1, 1'b1, gfc_pkg::DZ_RESET, gfc_pkg::DZ_RESET, 16'd0, 16'd0);
			else
				set_regs(1'($urandom), ($urandom_range(4) != 0),
					$urandom_range(4) == 0 ? 16'h8000 : 16'($urandom_range(16000)),
					$urandom_range(4) == 0 ? 16'h0000 : 16'($urandom_range(16000)),
					$urandom_range(3) == 0 ? 16'h0000 : 16'($urandom_range(32768)),
					$urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(20000)));
			// Long receiver hold-off while the sender keeps offering beats
			if (ph == 4)
				hold_off_cycles <= 300;
			queue_random(160);
			wait_drained();
		end

		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
